// ===== sv/fmm_pkg.sv =====
// Package with types, constants and field widths for the fault maturation monitor.
`timescale 1ns / 1ps
`default_nettype none

package fmm_pkg;

    localparam int unsigned ACCUM_W = 32;
    localparam int unsigned DT_W    = 16;

    localparam logic [ACCUM_W-1:0] PEND_MS   = 32'd6000;
    localparam logic [ACCUM_W-1:0] STORE_MS  = 32'd18000;
    localparam logic [ACCUM_W-1:0] SECOND_MS = 32'd32000;
    localparam logic [ACCUM_W-1:0] PERM_MS   = 32'd52000;

    localparam logic signed [11:0] WARM_DC  = 12'sd800;
    localparam logic [31:0]        WARM_SEC = 32'd90;

    localparam logic [13:0] MISFIRE_RPM_MIN = 14'd2200;
    localparam logic [9:0]  MISFIRE_THR_MIN = 10'd420;

    localparam logic [3:0]  LEAN_GEAR_MIN = 4'd3;
    localparam logic [11:0] LEAN_SPD_MIN  = 12'd450;
    localparam logic [11:0] LEAN_SPD_MAX  = 12'd900;
    localparam logic [9:0]  LEAN_THR_MIN  = 10'd160;
    localparam logic [9:0]  LEAN_THR_MAX  = 10'd320;

    localparam logic [11:0] CAT_SPD_MIN = 12'd550;
    localparam logic [11:0] CAT_SPD_MAX = 12'd880;
    localparam logic [9:0]  CAT_THR_MIN = 10'd140;
    localparam logic [9:0]  CAT_THR_MAX = 10'd300;

    localparam logic [7:0] RDY1_BASE     = 8'h07;
    localparam logic [7:0] RDY1_ENG_OFF  = 8'h10;
    localparam logic [7:0] RDY2_SUPPORT  = 8'hE5;
    localparam logic [7:0] RDY3_NOT_WARM = 8'h20;
    localparam logic [7:0] RDY3_ENG_OFF  = 8'h80;
    localparam logic [7:0] RDY3_PENDING  = 8'h01;

    localparam logic [1:0] COUNT_NONE      = 2'd0;
    localparam logic [1:0] COUNT_STORED    = 2'd1;
    localparam logic [1:0] COUNT_SECONDARY = 2'd2;

    localparam logic [1:0] PROFILE_LEAN     = 2'd0;
    localparam logic [1:0] PROFILE_MISFIRE  = 2'd1;
    localparam logic [1:0] PROFILE_CATALYST = 2'd2;

    typedef struct packed {
        logic               engine_on;
        logic               in_drive;
        logic [3:0]         gear;
        logic [11:0]        speed_dkph;
        logic [9:0]         throttle_dpct;
        logic [13:0]        engine_rpm;
        logic signed [11:0] coolant_dc;
        logic [31:0]        runtime_sec;
        logic [DT_W-1:0]    elapsed_ms;
    } fmm_snap_t;

    typedef struct packed {
        logic               pending_flag;
        logic               stored_flag;
        logic               secondary_flag;
        logic               permanent_flag;
        logic               lamp_on;
        logic [1:0]         fault_count;
        logic [7:0]         readiness_byte0;
        logic [7:0]         readiness_byte1;
        logic [7:0]         readiness_byte2;
        logic [7:0]         readiness_byte3;
        logic [ACCUM_W-1:0] active_time;
    } fmm_result_t;

endpackage

`default_nettype wire

// ===== sv/fmm_if.sv =====
// Valid/ready channel interfaces for engine snapshots and monitor results.
`timescale 1ns / 1ps
`default_nettype none

interface fmm_snap_if
    import fmm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               engine_on;
    logic               in_drive;
    logic [3:0]         gear;
    logic [11:0]        speed_dkph;
    logic [9:0]         throttle_dpct;
    logic [13:0]        engine_rpm;
    logic signed [11:0] coolant_dc;
    logic [31:0]        runtime_sec;
    logic [DT_W-1:0]    elapsed_ms;

    modport source (
        output valid, engine_on, in_drive, gear, speed_dkph, throttle_dpct,
               engine_rpm, coolant_dc, runtime_sec, elapsed_ms,
        input  ready
    );
    modport sink (
        input  valid, engine_on, in_drive, gear, speed_dkph, throttle_dpct,
               engine_rpm, coolant_dc, runtime_sec, elapsed_ms,
        output ready
    );
endinterface

interface fmm_res_if
    import fmm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               pending_flag;
    logic               stored_flag;
    logic               secondary_flag;
    logic               permanent_flag;
    logic               lamp_on;
    logic [1:0]         fault_count;
    logic [7:0]         readiness_byte0;
    logic [7:0]         readiness_byte1;
    logic [7:0]         readiness_byte2;
    logic [7:0]         readiness_byte3;
    logic [ACCUM_W-1:0] active_time;

    modport source (
        output valid, pending_flag, stored_flag, secondary_flag, permanent_flag,
               lamp_on, fault_count, readiness_byte0, readiness_byte1,
               readiness_byte2, readiness_byte3, active_time,
        input  ready
    );
    modport sink (
        input  valid, pending_flag, stored_flag, secondary_flag, permanent_flag,
               lamp_on, fault_count, readiness_byte0, readiness_byte1,
               readiness_byte2, readiness_byte3, active_time,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/fmm_window.sv =====
// Operating window decode: decides whether the fault is active on a snapshot.
`timescale 1ns / 1ps
`default_nettype none

module fmm_window
    import fmm_pkg::*;
(
    input  wire logic [1:0] profile,
    input  wire fmm_snap_t  snap,
    output logic            active
);

    logic lean_hit;
    logic misfire_hit;
    logic catalyst_hit;

    always_comb
    begin
        lean_hit = (snap.gear >= LEAN_GEAR_MIN)
                && (snap.speed_dkph >= LEAN_SPD_MIN) && (snap.speed_dkph <= LEAN_SPD_MAX)
                && (snap.throttle_dpct >= LEAN_THR_MIN)
                && (snap.throttle_dpct <= LEAN_THR_MAX);
        misfire_hit = (snap.engine_rpm >= MISFIRE_RPM_MIN)
                   && (snap.throttle_dpct >= MISFIRE_THR_MIN);
        catalyst_hit = (snap.runtime_sec >= WARM_SEC)
                    && (snap.speed_dkph >= CAT_SPD_MIN) && (snap.speed_dkph <= CAT_SPD_MAX)
                    && (snap.throttle_dpct >= CAT_THR_MIN)
                    && (snap.throttle_dpct <= CAT_THR_MAX);
    end

    always_comb
    begin
        if (!snap.engine_on || !snap.in_drive)
        begin
            active = 1'b0;
        end
        else
        begin
            // The unused fourth code falls back to the lean cruise window.
            case (profile)
                PROFILE_MISFIRE:  active = misfire_hit;
                PROFILE_CATALYST: active = catalyst_hit;
                default:          active = lean_hit;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/fmm_accum.sv =====
// Active time accumulator with saturating growth, floored decay and stored latch.
`timescale 1ns / 1ps
`default_nettype none

module fmm_accum
    import fmm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               clear,
    input  wire logic               update,
    input  wire logic               active,
    input  wire logic [DT_W-1:0]    elapsed_ms,
    output logic      [ACCUM_W-1:0] accum_after
);

    logic [ACCUM_W-1:0] accum_reg;
    logic [ACCUM_W-1:0] accum_next;
    logic [ACCUM_W:0]   sum;
    logic [DT_W:0]      decay;
    logic [ACCUM_W-1:0] decay_ext;

    always_comb
    begin
        sum       = {1'b0, accum_reg} + {{(ACCUM_W + 1 - DT_W){1'b0}}, elapsed_ms};
        decay     = {elapsed_ms, 1'b0};
        decay_ext = {{(ACCUM_W - DT_W - 1){1'b0}}, decay};
        if (active)
        begin
            accum_after = sum[ACCUM_W] ? {ACCUM_W{1'b1}} : sum[ACCUM_W-1:0];
        end
        else if ((accum_reg < STORE_MS) && (accum_reg != '0))
        begin
            accum_after = (accum_reg > decay_ext) ? (accum_reg - decay_ext) : '0;
        end
        else
        begin
            // Once the fault is stored it no longer decays.
            accum_after = accum_reg;
        end
    end

    always_comb
    begin
        if (clear)
        begin
            accum_next = '0;
        end
        else if (update)
        begin
            accum_next = accum_after;
        end
        else
        begin
            accum_next = accum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
        end
        else
        begin
            accum_reg <= accum_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fmm_report.sv =====
// Threshold flags, lamp, fault count and readiness bytes from the accumulator.
`timescale 1ns / 1ps
`default_nettype none

module fmm_report
    import fmm_pkg::*;
(
    input  wire logic [ACCUM_W-1:0] accum,
    input  wire fmm_snap_t          snap,
    output fmm_result_t             result
);

    logic pend;
    logic stor;
    logic sec;
    logic warm;

    always_comb
    begin
        pend = (accum >= PEND_MS);
        stor = (accum >= STORE_MS);
        sec  = (accum >= SECOND_MS);
        warm = (snap.coolant_dc >= WARM_DC) && (snap.runtime_sec >= WARM_SEC);

        result.pending_flag   = pend;
        result.stored_flag    = stor;
        result.secondary_flag = sec;
        result.permanent_flag = (accum >= PERM_MS);
        result.lamp_on        = stor;
        if (!stor)
        begin
            result.fault_count = COUNT_NONE;
        end
        else if (sec)
        begin
            result.fault_count = COUNT_SECONDARY;
        end
        else
        begin
            result.fault_count = COUNT_STORED;
        end
        result.readiness_byte0 = {stor, 5'b0, result.fault_count};
        result.readiness_byte1 = RDY1_BASE | (snap.engine_on ? 8'h00 : RDY1_ENG_OFF);
        result.readiness_byte2 = RDY2_SUPPORT;
        result.readiness_byte3 = (warm ? 8'h00 : RDY3_NOT_WARM)
                               | (snap.engine_on ? 8'h00 : RDY3_ENG_OFF)
                               | ((pend && !stor) ? RDY3_PENDING : 8'h00);
        result.active_time     = accum;
    end

endmodule

`default_nettype wire

// ===== sv/fault_maturation_monitor.sv =====
// Each snapshot is registered in the input stage, then its result in res_reg.
// Throughput: one snapshot per cycle if the result is not held; a two-entry
// pipeline lets one beat into an empty input stage while a result is held.
// Reset clears the accumulator, the profile (lean cruise) and both valid flags.
// A profile write clears the accumulator.
`timescale 1ns / 1ps
`default_nettype none

module fault_maturation_monitor
    import fmm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    fmm_snap_if.sink        snap,
    fmm_res_if.source       res
);

    logic [1:0]  profile_q_reg;
    logic        s1_valid_reg;
    fmm_snap_t   s1_snap_reg;
    logic        res_valid_reg;
    fmm_result_t res_reg;

    logic        res_free;
    logic        s1_fire;
    logic        snap_fire;
    logic        active;
    logic [ACCUM_W-1:0] accum_after;
    fmm_snap_t   snap_in;
    fmm_result_t result;

    assign res_free  = !res_valid_reg || res.ready;
    assign s1_fire   = s1_valid_reg && res_free;
    assign snap.ready = !s1_valid_reg || res_free;
    assign snap_fire = snap.valid && snap.ready;

    always_comb
    begin
        snap_in.engine_on      = snap.engine_on;
        snap_in.in_drive       = snap.in_drive;
        snap_in.gear           = snap.gear;
        snap_in.speed_dkph     = snap.speed_dkph;
        snap_in.throttle_dpct  = snap.throttle_dpct;
        snap_in.engine_rpm     = snap.engine_rpm;
        snap_in.coolant_dc     = snap.coolant_dc;
        snap_in.runtime_sec    = snap.runtime_sec;
        snap_in.elapsed_ms     = snap.elapsed_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_q_reg <= PROFILE_LEAN;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                profile_q_reg <= cfg_wdata;
            end
            if (snap.ready)
            begin
                s1_valid_reg <= snap.valid;
            end
            if (res_free)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (snap_fire)
        begin
            s1_snap_reg <= snap_in;
        end
        if (s1_fire)
        begin
            res_reg <= result;
        end
    end

    fmm_window u_window (
        .profile (profile_q_reg),
        .snap    (s1_snap_reg),
        .active  (active)
    );

    // A profile write clears the accumulator.
    fmm_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (cfg_we),
        .update      (s1_fire),
        .active      (active),
        .elapsed_ms  (s1_snap_reg.elapsed_ms),
        .accum_after (accum_after)
    );

    fmm_report u_report (
        .accum  (accum_after),
        .snap   (s1_snap_reg),
        .result (result)
    );

    assign res.valid           = res_valid_reg;
    assign res.pending_flag    = res_reg.pending_flag;
    assign res.stored_flag     = res_reg.stored_flag;
    assign res.secondary_flag  = res_reg.secondary_flag;
    assign res.permanent_flag  = res_reg.permanent_flag;
    assign res.lamp_on         = res_reg.lamp_on;
    assign res.fault_count     = res_reg.fault_count;
    assign res.readiness_byte0 = res_reg.readiness_byte0;
    assign res.readiness_byte1 = res_reg.readiness_byte1;
    assign res.readiness_byte2 = res_reg.readiness_byte2;
    assign res.readiness_byte3 = res_reg.readiness_byte3;
    assign res.active_time     = res_reg.active_time;

endmodule

`default_nettype wire

// ===== sv/fmm_checker.sv =====
// Port-level checker for the fault maturation monitor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fmm_checker
    import fmm_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               pending_flag,
    input wire logic               stored_flag,
    input wire logic               lamp_on,
    input wire logic [1:0]         fault_count,
    input wire logic [7:0]         readiness_byte2,
    input wire logic [ACCUM_W-1:0] active_time
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_stored_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lamp_on == stored_flag)
                   && ((fault_count != COUNT_NONE) == stored_flag))
        else $error("lamp or fault count disagrees with stored flag");

    a_stored_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((active_time >= STORE_MS) == stored_flag)
                   && (!stored_flag || pending_flag))
        else $error("flags disagree with active time");

    a_support_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (readiness_byte2 == RDY2_SUPPORT))
        else $error("support byte wrong");

endmodule

bind fault_maturation_monitor fmm_checker u_fmm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (res.valid),
    .out_ready       (res.ready),
    .pending_flag    (res.pending_flag),
    .stored_flag     (res.stored_flag),
    .lamp_on         (res.lamp_on),
    .fault_count     (res.fault_count),
    .readiness_byte2 (res.readiness_byte2),
    .active_time     (res.active_time)
);

`default_nettype wire
